/* sv/aes128_gcm_engine_assert.svh */
// Assertion macros for the GCM engine.
`ifndef AES128_GCM_ENGINE_ASSERT_SVH
`define AES128_GCM_ENGINE_ASSERT_SVH

// same-cycle implication
`define AGCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/agcm_pkg.sv */
// ----------------------------------------------------------------------------
// agcm_pkg
// Types, codes and round functions used by the GCM engine.
// ----------------------------------------------------------------------------
package agcm_pkg;

    localparam int BLK_W   = 128;
    localparam int LEN_W   = 61;
    localparam int CNT_W   = 5;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = BLK_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);
    localparam int ROUNDS  = 10;
    localparam int RND_W   = 4;
    localparam int ADDR_W  = 5;

    localparam logic [BLK_W-1:0] GF_POLY = {8'he1, 120'd0};

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_AAD    = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_MISMATCH = 2'd1,
        STAT_ORDER    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AAD  = 2'd1,
        PH_TEXT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AESH,
        ST_AESJ,
        ST_AESC,
        ST_GHASH,
        ST_RES
    } state_t;

    typedef enum logic [1:0] {
        REG_KEY_HI  = 2'd0,
        REG_KEY_LO  = 2'd1,
        REG_DECRYPT = 2'd2
    } reg_idx_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i downto 120-8i
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] b, input int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLK_W-1:0] keep_bytes(input logic [BLK_W-1:0] b,
                                                    input logic [CNT_W-1:0] n);
        logic [BLK_W-1:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (CNT_W'(i) < n)
            begin
                m[BLK_W-1-8*i -: 8] = 8'hff;
            end
        end
        return b & m;
    endfunction

    function automatic logic [BLK_W-1:0] next_round_key(input logic [BLK_W-1:0] rk,
                                                        input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a, b, d, e, x;
        logic [BLK_W-1:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[get_byte(s, i)];
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                u[4*c+row] = t[4*((c+row)%4)+row];
            end
        end
        if (!last)
        begin
            for (int c = 0; c < 4; c++) begin
                a = u[4*c]; b = u[4*c+1]; d = u[4*c+2]; e = u[4*c+3];
                x = a ^ b ^ d ^ e;
                u[4*c]   = a ^ x ^ xtime(a ^ b);
                u[4*c+1] = b ^ x ^ xtime(b ^ d);
                u[4*c+2] = d ^ x ^ xtime(d ^ e);
                u[4*c+3] = e ^ x ^ xtime(e ^ a);
            end
        end
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[BLK_W-1-8*i -: 8] = u[i];
        end
        return r ^ rk;
    endfunction

endpackage

/* sv/agcm_if.sv */
// ----------------------------------------------------------------------------
// agcm request / result channels
// Valid-ready channels carrying engine requests and engine results.
// ----------------------------------------------------------------------------
interface agcm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  byte_count;

    modport source (output valid, command, data_hi, data_lo, byte_count, input ready);
    modport sink   (input valid, command, data_hi, data_lo, byte_count, output ready);
endinterface

interface agcm_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic [4:0]  result_bytes;
    logic [1:0]  status;

    modport source (output valid, result_kind, result_hi, result_lo, result_bytes, status,
                    input ready);
    modport sink   (input valid, result_kind, result_hi, result_lo, result_bytes, status,
                    output ready);
endinterface

/* sv/aes128_gcm_engine.sv */
// ----------------------------------------------------------------------------
// aes128_gcm_engine
// AES-128-GCM message engine: one AES round per cycle, GHASH four bits a cycle.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// req       in   valid/ready    command, data_hi, data_lo, byte_count
// rsp       out  valid/ready    result_kind, result_hi/lo, result_bytes, status
// apb       in   psel/penable   64-bit registers at 0x00, 0x08, 0x10
//
// One request at a time. Start: two AES passes of 10 rounds. AAD: GHASH digit
// loop. Text: AES pass, GHASH digit loop, then the result state. Finish: GHASH
// digit loop, then the result state. Out-of-order and empty text requests go
// straight to the result state. The result sits in an output register, so the
// next request is taken while it waits; a new result waits in the result state
// until that register frees. rst_n clears control state and the message phase.
module aes128_gcm_engine
    import agcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    agcm_req_if.sink          req,
    agcm_rsp_if.source        rsp
);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [63:0]          key_hi_reg, key_lo_reg;
    logic                 decrypt_reg;
    logic [BLK_W-1:0]     key_q_reg;
    logic [BLK_W-1:0]     h_reg, acc_reg, ctr_reg, mask_reg;
    logic [LEN_W-1:0]     aad_len_reg, text_len_reg;

    logic [BLK_W-1:0]     aes_s_reg, rk_reg;
    logic [7:0]           rcon_reg;
    logic [RND_W-1:0]     rnd_reg;

    logic [BLK_W-1:0]     x_reg, v_reg, z_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;

    cmd_t                 cmd_reg;
    logic [BLK_W-1:0]     dat_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 dec_reg;

    logic                 r_kind_reg;
    logic [BLK_W-1:0]     r_data_reg;
    logic [CNT_W-1:0]     r_bytes_reg;
    status_t              r_stat_reg;

    logic                 o_valid_reg, o_kind_reg;
    logic [BLK_W-1:0]     o_data_reg;
    logic [CNT_W-1:0]     o_bytes_reg;
    status_t              o_stat_reg;

    // combinational
    logic             in_acc, out_free, cfg_wr, aes_last, gh_last;
    cmd_t             in_cmd;
    logic [CNT_W-1:0] in_n;
    logic [BLK_W-1:0] in_blk, rk_step, aes_step, z_step, v_step, ctr_inc, tag;
    logic             bad_order;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];

    always_comb
    begin
        case (reg_idx)
            REG_KEY_HI:  prdata = key_hi_reg;
            REG_KEY_LO:  prdata = key_lo_reg;
            REG_DECRYPT: prdata = {63'd0, decrypt_reg};
            default:     prdata = 64'd0;
        endcase
    end

    assign in_cmd  = cmd_t'(req.command);
    assign in_n    = (req.byte_count > CNT_W'(16)) ? CNT_W'(16) : req.byte_count;
    assign in_blk  = {req.data_hi, req.data_lo};
    assign in_acc  = req.valid && req.ready;
    assign out_free = !o_valid_reg || rsp.ready;

    always_comb
    begin
        case (in_cmd)
            CMD_AAD:    bad_order = (phase_reg != PH_AAD);
            CMD_TEXT:   bad_order = (phase_reg == PH_IDLE);
            CMD_FINISH: bad_order = (phase_reg == PH_IDLE);
            default:    bad_order = 1'b0;
        endcase
    end

    // AES round unit, key schedule runs alongside
    assign rk_step  = next_round_key(rk_reg, rcon_reg);
    assign aes_last = (rnd_reg == RND_W'(ROUNDS));
    assign aes_step = aes_round(aes_s_reg, rk_step, aes_last);

    assign ctr_inc = {ctr_reg[BLK_W-1:32], ctr_reg[31:0] + 32'd1};

    // GHASH digit: four bits of x, MSB first
    always_comb
    begin
        z_step = z_reg;
        v_step = v_reg;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (x_reg[BLK_W-1-j])
            begin
                z_step = z_step ^ v_step;
            end
            v_step = (v_step >> 1) ^ (v_step[0] ? GF_POLY : '0);
        end
    end
    assign gh_last = (dig_cnt_reg == DIG_CNT_W'(DIGITS-1));
    assign tag     = z_step ^ mask_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_cmd == CMD_START)
                        state_next = ST_AESH;
                    else if (bad_order)
                        state_next = ST_RES;
                    else if (in_cmd == CMD_AAD)
                        state_next = (in_n == '0) ? ST_IDLE : ST_GHASH;
                    else if (in_cmd == CMD_TEXT)
                        state_next = (in_n == '0) ? ST_RES : ST_AESC;
                    else
                        state_next = ST_GHASH;
                end
            end
            ST_AESH:  if (aes_last) state_next = ST_AESJ;
            ST_AESJ:  if (aes_last) state_next = ST_IDLE;
            ST_AESC:  if (aes_last) state_next = ST_GHASH;
            ST_GHASH:
            begin
                if (gh_last)
                    state_next = (cmd_reg == CMD_AAD) ? ST_IDLE : ST_RES;
            end
            ST_RES:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready        = (state_reg == ST_IDLE);
        rsp.valid        = o_valid_reg;
        rsp.result_kind  = o_kind_reg;
        rsp.result_hi    = o_data_reg[127:64];
        rsp.result_lo    = o_data_reg[63:0];
        rsp.result_bytes = o_bytes_reg;
        rsp.status       = o_stat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            decrypt_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            dig_cnt_reg  <= '0;
            rnd_reg      <= '0;
            h_reg        <= '0;
            acc_reg      <= '0;
            ctr_reg      <= '0;
            mask_reg     <= '0;
            aad_len_reg  <= '0;
            text_len_reg <= '0;
            key_q_reg    <= '0;
            aes_s_reg    <= '0;
            rk_reg       <= '0;
            rcon_reg     <= '0;
            x_reg        <= '0;
            v_reg        <= '0;
            z_reg        <= '0;
            cmd_reg      <= CMD_START;
            dat_reg      <= '0;
            n_reg        <= '0;
            dec_reg      <= 1'b0;
            r_kind_reg   <= 1'b0;
            r_data_reg   <= '0;
            r_bytes_reg  <= '0;
            r_stat_reg   <= STAT_OK;
            o_kind_reg   <= 1'b0;
            o_data_reg   <= '0;
            o_bytes_reg  <= '0;
            o_stat_reg   <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                case (reg_idx)
                    REG_KEY_HI:  key_hi_reg  <= pwdata;
                    REG_KEY_LO:  key_lo_reg  <= pwdata;
                    REG_DECRYPT: decrypt_reg <= pwdata[0];
                    default:     ;
                endcase
            end

            if (o_valid_reg && rsp.ready)
                o_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg <= in_cmd;
                        // finish carries the full expected tag, byte count ignored
                        dat_reg <= (in_cmd == CMD_FINISH) ? in_blk
                                                          : keep_bytes(in_blk, in_n);
                        n_reg   <= in_n;
                        dec_reg <= decrypt_reg;
                        r_kind_reg  <= 1'b1;
                        r_data_reg  <= '0;
                        r_bytes_reg <= '0;
                        r_stat_reg  <= STAT_ORDER;
                        if (in_cmd == CMD_START)
                        begin
                            key_q_reg    <= {key_hi_reg, key_lo_reg};
                            aes_s_reg    <= {key_hi_reg, key_lo_reg};
                            rk_reg       <= {key_hi_reg, key_lo_reg};
                            rcon_reg     <= 8'h01;
                            rnd_reg      <= RND_W'(1);
                            ctr_reg      <= {req.data_hi, req.data_lo[63:32], 32'd1};
                            acc_reg      <= '0;
                            aad_len_reg  <= '0;
                            text_len_reg <= '0;
                            phase_reg    <= PH_AAD;
                        end
                        else if (!bad_order)
                        begin
                            x_reg       <= acc_reg ^ keep_bytes(in_blk, in_n);
                            v_reg       <= h_reg;
                            z_reg       <= '0;
                            dig_cnt_reg <= '0;
                            case (in_cmd)
                                CMD_AAD:
                                begin
                                    aad_len_reg <= aad_len_reg + LEN_W'(in_n);
                                end
                                CMD_TEXT:
                                begin
                                    phase_reg   <= PH_TEXT;
                                    r_kind_reg  <= 1'b0;
                                    r_stat_reg  <= STAT_OK;
                                    if (in_n != '0)
                                    begin
                                        ctr_reg   <= ctr_inc;
                                        aes_s_reg <= ctr_inc ^ key_q_reg;
                                        rk_reg    <= key_q_reg;
                                        rcon_reg  <= 8'h01;
                                        rnd_reg   <= RND_W'(1);
                                    end
                                end
                                CMD_FINISH:
                                begin
                                    x_reg     <= acc_reg ^ {aad_len_reg, 3'd0,
                                                            text_len_reg, 3'd0};
                                    phase_reg <= PH_IDLE;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_AESH, ST_AESJ:
                begin
                    aes_s_reg <= aes_step;
                    rk_reg    <= rk_step;
                    rcon_reg  <= xtime(rcon_reg);
                    rnd_reg   <= rnd_reg + RND_W'(1);
                    if (aes_last)
                    begin
                        rnd_reg <= '0;
                        if (state_reg == ST_AESH)
                        begin
                            h_reg     <= aes_step;
                            aes_s_reg <= ctr_reg ^ key_q_reg;
                            rk_reg    <= key_q_reg;
                            rcon_reg  <= 8'h01;
                            rnd_reg   <= RND_W'(1);
                        end
                        else
                        begin
                            mask_reg <= aes_step;
                        end
                    end
                end
                ST_AESC:
                begin
                    aes_s_reg <= aes_step;
                    rk_reg    <= rk_step;
                    rcon_reg  <= xtime(rcon_reg);
                    rnd_reg   <= rnd_reg + RND_W'(1);
                    if (aes_last)
                    begin
                        rnd_reg      <= '0;
                        r_data_reg   <= keep_bytes(dat_reg ^ aes_step, n_reg);
                        r_bytes_reg  <= n_reg;
                        x_reg        <= acc_reg ^ (dec_reg ? dat_reg
                                                           : keep_bytes(dat_reg ^ aes_step, n_reg));
                        text_len_reg <= text_len_reg + LEN_W'(n_reg);
                    end
                end
                ST_GHASH:
                begin
                    x_reg       <= x_reg << DIGIT_W;
                    z_reg       <= z_step;
                    v_reg       <= v_step;
                    dig_cnt_reg <= dig_cnt_reg + DIG_CNT_W'(1);
                    if (gh_last)
                    begin
                        acc_reg <= z_step;
                        if (cmd_reg == CMD_FINISH)
                        begin
                            r_kind_reg <= 1'b1;
                            if (dec_reg)
                            begin
                                r_data_reg  <= '0;
                                r_bytes_reg <= '0;
                                r_stat_reg  <= (tag == dat_reg) ? STAT_OK : STAT_MISMATCH;
                            end
                            else
                            begin
                                r_data_reg  <= tag;
                                r_bytes_reg <= CNT_W'(16);
                                r_stat_reg  <= STAT_OK;
                            end
                        end
                    end
                end
                ST_RES:
                begin
                    if (out_free)
                    begin
                        o_valid_reg <= 1'b1;
                        o_kind_reg  <= r_kind_reg;
                        o_data_reg  <= r_data_reg;
                        o_bytes_reg <= r_bytes_reg;
                        o_stat_reg  <= r_stat_reg;
                    end
                end
                default: ;
            endcase
        end
    end

`include "aes128_gcm_engine_assert.svh"

    `AGCM_ASSERT_NOW(a_digit_idle, state_reg != ST_GHASH, dig_cnt_reg == '0, "digit count stray")
    `AGCM_ASSERT_NOW(a_rnd_range, state_reg == ST_AESH || state_reg == ST_AESC, rnd_reg != '0 && rnd_reg <= RND_W'(ROUNDS), "AES round out of range")
    `AGCM_ASSERT_NEXT(a_start_aes, in_acc && in_cmd == CMD_START, state_reg == ST_AESH, "start did not launch key pass")

endmodule
